### src/eha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eha_pkg: shared types and constants
// Fixed-point formats, sequencer states, divider request/response and the
// decade table of the autorange core.
// ----------------------------------------------------------------------------
package eha_pkg;

    localparam int SW    = 48;   // sample width, signed Q31.16
    localparam int EW    = 50;   // envelope working width
    localparam int VW    = 54;   // range working width
    localparam int DW    = 50;   // divisor and remainder width
    localparam int NW    = 64;   // dividend shift width
    localparam int QW    = 32;   // quotient width
    localparam int CW    = 7;    // iteration counter width
    localparam int FRAC  = 16;
    localparam int RNG_W = 47;   // range output width
    localparam int LVL_W = 17;
    localparam int MUL_W = 14;
    localparam int PW    = EW + MUL_W;
    localparam int NUM_BITS = 49; // magnitude bits of a range edge

    localparam logic signed [VW-1:0] ONE_V = 54'sd65536;
    localparam logic signed [VW-1:0] MAX_V = 54'sd140737488355327;
    localparam logic signed [MUL_W-1:0] REL_Q16 = 14'sd1311;
    localparam logic signed [MUL_W-1:0] PAD_Q16 = 14'sd6554;
    localparam logic [QW-1:0] UNITY_Q16 = 32'd65536;
    localparam logic [QW-1:0] SAT_Q16   = 32'hFFFF_FFFF;
    localparam logic [3:0] TOP_DECADE = 4'd13;

    localparam logic [1:0] REG_PIN   = 2'd0;
    localparam logic [1:0] REG_ROUND = 2'd1;
    localparam logic [1:0] REG_HOLD  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_LO, ST_UPD_LO, ST_MUL_HI, ST_UPD_HI, ST_MUL_PAD, ST_PAD,
        ST_SPAN, ST_SEARCH, ST_SELECT, ST_WAIT_MN, ST_WAIT_MX, ST_CLAMP_A,
        ST_CLAMP_B, ST_RATIO, ST_LEVEL, ST_WAIT_Q, ST_OUT
    } state_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] rem_init;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        logic [CW-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
        logic [DW-1:0] rem;
    } div_rsp_t;

    // round(10^(k-4) * 2^16), k = 0..13
    function automatic logic [DW-1:0] decade(input logic [3:0] k);
        logic [DW-1:0] v;
        unique case (k)
            4'd0:    v = 50'd7;
            4'd1:    v = 50'd66;
            4'd2:    v = 50'd655;
            4'd3:    v = 50'd6554;
            4'd4:    v = 50'd65536;
            4'd5:    v = 50'd655360;
            4'd6:    v = 50'd6553600;
            4'd7:    v = 50'd65536000;
            4'd8:    v = 50'd655360000;
            4'd9:    v = 50'd6553600000;
            4'd10:   v = 50'd65536000000;
            4'd11:   v = 50'd655360000000;
            4'd12:   v = 50'd6553600000000;
            4'd13:   v = 50'd65536000000000;
            default: v = 50'd65536000000000;
        endcase
        return v;
    endfunction

endpackage

### src/eha_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eha_div: shared restoring divider
// One quotient bit per cycle; gives the quotient and the final remainder.
// ----------------------------------------------------------------------------
module eha_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  eha_pkg::div_req_t req,
    output eha_pkg::div_rsp_t rsp
);
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [eha_pkg::CW-1:0]     cnt_reg, cnt_next;
    logic [eha_pkg::DW-1:0]     rem_reg, rem_next;
    logic [eha_pkg::NW-1:0]     num_reg, num_next;
    logic [eha_pkg::DW-1:0]     den_reg, den_next;
    logic [eha_pkg::QW-1:0]     quot_reg, quot_next;
    logic [eha_pkg::DW:0]       trial;
    logic [eha_pkg::DW:0]       diff;
    logic                       ge;

    always_comb begin
        trial = {rem_reg, num_reg[eha_pkg::NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            num_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[eha_pkg::DW-1:0] : trial[eha_pkg::DW-1:0];
            num_next  = {num_reg[eha_pkg::NW-2:0], 1'b0};
            quot_next = {quot_reg[eha_pkg::QW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == eha_pkg::CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

### src/envelope_hold_autorange_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_hold_autorange_core: peak-hold envelope with 1-2-5 autorange
// Tracks low/high envelopes of a Q31.16 stream and reports a display range,
// rescale ratio and normalized level for every sample.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time; s_tready stays low until its result is
// loaded into the output register. A sample with s_tuser[0] low goes straight
// to the output step. A valid one runs through a small sequencer around one
// shared multiplier and one shared radix-2 divider: envelope and clamp steps,
// a decade search from the top decade down and a step select, up to two
// remainder passes when rounding is on, and up to two divisions for ratio and
// level. The result then waits in the output step while the output register
// still holds a beat that m_tready has not taken.
module envelope_hold_autorange_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [47:0] sample
    input  logic [0:0]   s_tuser,   // [0] sample_valid
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // [46:0] range_low, [93:47] range_high,
                                    // [125:94] rescale_ratio, [142:126] level
    output logic [1:0]   m_tuser,   // [0] range_changed, [1] invalid_flag
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int VW = eha_pkg::VW;
    localparam int EW = eha_pkg::EW;
    localparam int DW = eha_pkg::DW;
    localparam int NW = eha_pkg::NW;
    localparam int QW = eha_pkg::QW;

    eha_pkg::state_t state_reg, state_next;

    logic        pin_reg, pin_next;
    logic        round_reg, round_next;
    logic [7:0]  hold_samples_reg, hold_samples_next;

    logic signed [eha_pkg::SW-1:0] s_reg, s_next;
    logic                          valid_reg, valid_next;
    logic signed [EW-1:0]          low_reg, low_next;
    logic signed [EW-1:0]          high_reg, high_next;
    logic [7:0]                    hold_reg, hold_next;
    logic signed [VW-1:0]          shown_low_reg, shown_low_next;
    logic signed [VW-1:0]          shown_high_reg, shown_high_next;
    logic signed [VW-1:0]          old_lo_reg, old_lo_next;
    logic signed [VW-1:0]          old_hi_reg, old_hi_next;
    logic [QW-1:0]                 ratio_reg, ratio_next;
    logic [eha_pkg::LVL_W-1:0]     level_reg, level_next;
    logic signed [eha_pkg::PW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0]          mn_reg, mn_next;
    logic signed [VW-1:0]          mx_reg, mx_next;
    logic [VW-1:0]                 x_reg, x_next;
    logic [3:0]                    k_reg, k_next;
    logic [DW-1:0]                 e_reg, e_next;
    logic [DW-1:0]                 st_reg, st_next;
    logic                          q_level_reg, q_level_next;

    logic                          m_valid_reg, m_valid_next;
    logic [eha_pkg::RNG_W-1:0]     out_lo_reg, out_lo_next;
    logic [eha_pkg::RNG_W-1:0]     out_hi_reg, out_hi_next;
    logic [QW-1:0]                 out_ratio_reg, out_ratio_next;
    logic [eha_pkg::LVL_W-1:0]     out_level_reg, out_level_next;
    logic                          out_changed_reg, out_changed_next;
    logic                          out_inv_reg, out_inv_next;

    eha_pkg::div_req_t div_req;
    eha_pkg::div_rsp_t div_rsp;

    logic signed [EW-1:0]          mul_a;
    logic signed [eha_pkg::MUL_W-1:0] mul_b;
    logic signed [47:0]            mul_q;
    logic signed [EW-1:0]          s_e, hi_a, low_c;
    logic signed [VW-1:0]          s_v, span_w, mn_c, mx_c, n_old, d_new, lv_diff;
    logic [VW-1:0]                 dec_v, e_v, e2_v, e5_v, st_v, r_v;
    logic [DW-1:0]                 dec_k, st_val;
    logic                          changed_w;
    logic                          cfg_wr;

    eha_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        pin_next          = pin_reg;
        round_next        = round_reg;
        hold_samples_next = hold_samples_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                eha_pkg::REG_PIN:   pin_next          = pwdata[0];
                eha_pkg::REG_ROUND: round_next        = pwdata[0];
                eha_pkg::REG_HOLD:  hold_samples_next = pwdata[7:0];
                default: ;
            endcase
        end
        unique case (paddr[3:2])
            eha_pkg::REG_PIN:   prdata = {31'd0, pin_reg};
            eha_pkg::REG_ROUND: prdata = {31'd0, round_reg};
            eha_pkg::REG_HOLD:  prdata = {24'd0, hold_samples_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == eha_pkg::ST_IDLE);
    assign mul_q    = $signed(prod_reg[eha_pkg::PW-1:eha_pkg::FRAC]);

    always_comb begin
        state_next       = state_reg;
        s_next           = s_reg;
        valid_next       = valid_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        hold_next        = hold_reg;
        shown_low_next   = shown_low_reg;
        shown_high_next  = shown_high_reg;
        old_lo_next      = old_lo_reg;
        old_hi_next      = old_hi_reg;
        ratio_next       = ratio_reg;
        level_next       = level_reg;
        prod_next        = prod_reg;
        mn_next          = mn_reg;
        mx_next          = mx_reg;
        x_next           = x_reg;
        k_next           = k_reg;
        e_next           = e_reg;
        st_next          = st_reg;
        q_level_next     = q_level_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_lo_next      = out_lo_reg;
        out_hi_next      = out_hi_reg;
        out_ratio_next   = out_ratio_reg;
        out_level_next   = out_level_reg;
        out_changed_next = out_changed_reg;
        out_inv_next     = out_inv_reg;
        div_req          = '0;

        s_e     = EW'(s_reg);
        s_v     = VW'(s_reg);
        mul_a   = s_e - low_reg;
        mul_b   = eha_pkg::REL_Q16;
        hi_a    = high_reg;
        low_c   = (low_reg < 0) ? '0 : low_reg;
        span_w  = mx_reg - mn_reg;
        dec_k   = eha_pkg::decade(k_reg);
        dec_v   = VW'(dec_k);
        e_v     = VW'(e_reg);
        e2_v    = e_v << 1;
        e5_v    = (e_v << 2) + e_v;
        st_v    = VW'(st_reg);
        r_v     = VW'(div_rsp.rem);
        st_val  = '0;
        mn_c    = (mn_reg < 0) ? '0 : mn_reg;
        mx_c    = (mx_reg > eha_pkg::MAX_V) ? eha_pkg::MAX_V : mx_reg;
        n_old   = old_hi_reg - old_lo_reg;
        d_new   = shown_high_reg - shown_low_reg;
        lv_diff = s_v - shown_low_reg;
        changed_w = (shown_low_reg != old_lo_reg) || (shown_high_reg != old_hi_reg);

        unique case (state_reg)
            eha_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    s_next      = $signed(s_tdata);
                    valid_next  = s_tuser[0];
                    old_lo_next = shown_low_reg;
                    old_hi_next = shown_high_reg;
                    if (s_tuser[0]) begin
                        state_next = eha_pkg::ST_MUL_LO;
                    end else begin
                        // pin only; ratio repeats, level drops to zero
                        if (pin_reg) shown_low_next = '0;
                        level_next = '0;
                        state_next = eha_pkg::ST_OUT;
                    end
                end
            end
            eha_pkg::ST_MUL_LO: begin
                prod_next  = mul_a * mul_b;
                state_next = eha_pkg::ST_UPD_LO;
            end
            eha_pkg::ST_UPD_LO: begin
                low_next   = (s_e < low_reg) ? s_e : low_reg + EW'(mul_q);
                state_next = eha_pkg::ST_MUL_HI;
            end
            eha_pkg::ST_MUL_HI: begin
                mul_a      = s_e - high_reg;
                prod_next  = mul_a * mul_b;
                state_next = eha_pkg::ST_UPD_HI;
            end
            eha_pkg::ST_UPD_HI: begin
                if (s_e > high_reg) begin
                    hi_a      = high_reg + ((s_e - high_reg) >>> 2);
                    hold_next = hold_samples_reg;
                end else if (hold_reg != 8'd0) begin
                    hold_next = hold_reg - 8'd1;
                end else begin
                    hi_a = high_reg + EW'(mul_q);
                end
                low_next   = low_c;
                high_next  = (hi_a < low_c) ? low_c : hi_a;
                state_next = eha_pkg::ST_MUL_PAD;
            end
            eha_pkg::ST_MUL_PAD: begin
                mul_a      = high_reg - low_reg;
                mul_b      = eha_pkg::PAD_Q16;
                prod_next  = mul_a * mul_b;
                state_next = eha_pkg::ST_PAD;
            end
            eha_pkg::ST_PAD: begin
                mn_next    = VW'(low_reg) - VW'(mul_q);
                mx_next    = VW'(high_reg) + VW'(mul_q);
                state_next = eha_pkg::ST_SPAN;
            end
            eha_pkg::ST_SPAN: begin
                if (round_reg && (mx_reg > mn_reg)) begin
                    x_next     = $unsigned(span_w >>> 2);
                    k_next     = eha_pkg::TOP_DECADE;
                    state_next = eha_pkg::ST_SEARCH;
                end else begin
                    state_next = eha_pkg::ST_CLAMP_A;
                end
            end
            eha_pkg::ST_SEARCH: begin
                // walk down from the top decade, lowest decade as floor
                if (x_reg == '0 || dec_v <= x_reg || k_reg == 4'd0) begin
                    e_next     = dec_k;
                    state_next = eha_pkg::ST_SELECT;
                end else begin
                    k_next = k_reg - 4'd1;
                end
            end
            eha_pkg::ST_SELECT: begin
                priority if (x_reg == '0) st_val = DW'(eha_pkg::ONE_V);
                else if (x_reg <= e_v)    st_val = e_reg;
                else if (x_reg <= e2_v)   st_val = DW'(e2_v);
                else if (x_reg <= e5_v)   st_val = DW'(e5_v);
                else                      st_val = DW'(e5_v << 1);
                st_next       = st_val;
                div_req.start = 1'b1;
                div_req.den   = st_val;
                div_req.iters = eha_pkg::CW'(eha_pkg::NUM_BITS);
                if (mn_reg >= 0) begin
                    div_req.num = {mn_reg[eha_pkg::NUM_BITS-1:0],
                                   (NW - eha_pkg::NUM_BITS)'(0)};
                    state_next  = eha_pkg::ST_WAIT_MN;
                end else begin
                    // negative floor clamps to zero later
                    div_req.num = {mx_reg[eha_pkg::NUM_BITS-1:0],
                                   (NW - eha_pkg::NUM_BITS)'(0)};
                    state_next  = eha_pkg::ST_WAIT_MX;
                end
            end
            eha_pkg::ST_WAIT_MN: begin
                if (div_rsp.done) begin
                    mn_next       = mn_reg - $signed(r_v);
                    div_req.start = 1'b1;
                    div_req.den   = st_reg;
                    div_req.iters = eha_pkg::CW'(eha_pkg::NUM_BITS);
                    div_req.num   = {mx_reg[eha_pkg::NUM_BITS-1:0],
                                     (NW - eha_pkg::NUM_BITS)'(0)};
                    state_next    = eha_pkg::ST_WAIT_MX;
                end
            end
            eha_pkg::ST_WAIT_MX: begin
                if (div_rsp.done) begin
                    // round up to a step, then two steps of headroom
                    if (div_rsp.rem == '0)
                        mx_next = mx_reg + $signed(st_v << 1);
                    else
                        mx_next = mx_reg + $signed(st_v << 1) + $signed(st_v - r_v);
                    state_next = eha_pkg::ST_CLAMP_A;
                end
            end
            eha_pkg::ST_CLAMP_A: begin
                mn_next    = mn_c;
                mx_next    = (mx_reg > mn_c) ? mx_reg : mn_c + eha_pkg::ONE_V;
                state_next = eha_pkg::ST_CLAMP_B;
            end
            eha_pkg::ST_CLAMP_B: begin
                shown_high_next = mx_c;
                if (pin_reg)
                    shown_low_next = '0;
                else
                    shown_low_next = (mn_reg >= mx_c) ? mx_c - eha_pkg::ONE_V : mn_reg;
                state_next = eha_pkg::ST_RATIO;
            end
            eha_pkg::ST_RATIO: begin
                if (!changed_w) begin
                    ratio_next = eha_pkg::UNITY_Q16;
                    state_next = eha_pkg::ST_LEVEL;
                end else if ((n_old >>> eha_pkg::FRAC) >= d_new) begin
                    ratio_next = eha_pkg::SAT_Q16;
                    state_next = eha_pkg::ST_LEVEL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = DW'(n_old >>> eha_pkg::FRAC);
                    div_req.num      = {n_old[eha_pkg::FRAC-1:0], (NW - eha_pkg::FRAC)'(0)};
                    div_req.den      = DW'(d_new);
                    div_req.iters    = eha_pkg::CW'(QW);
                    q_level_next     = 1'b0;
                    state_next       = eha_pkg::ST_WAIT_Q;
                end
            end
            eha_pkg::ST_LEVEL: begin
                if (s_v <= shown_low_reg) begin
                    level_next = '0;
                    state_next = eha_pkg::ST_OUT;
                end else if (lv_diff >= d_new) begin
                    level_next = eha_pkg::LVL_W'(eha_pkg::UNITY_Q16);
                    state_next = eha_pkg::ST_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = DW'(lv_diff >>> eha_pkg::FRAC);
                    div_req.num      = {lv_diff[eha_pkg::FRAC-1:0], (NW - eha_pkg::FRAC)'(0)};
                    div_req.den      = DW'(d_new);
                    div_req.iters    = eha_pkg::CW'(QW);
                    q_level_next     = 1'b1;
                    state_next       = eha_pkg::ST_WAIT_Q;
                end
            end
            eha_pkg::ST_WAIT_Q: begin
                if (div_rsp.done) begin
                    if (q_level_reg) begin
                        level_next = div_rsp.quot[eha_pkg::LVL_W-1:0];
                        state_next = eha_pkg::ST_OUT;
                    end else begin
                        ratio_next = div_rsp.quot;
                        state_next = eha_pkg::ST_LEVEL;
                    end
                end
            end
            eha_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next     = 1'b1;
                    out_lo_next      = shown_low_reg[eha_pkg::RNG_W-1:0];
                    out_hi_next      = shown_high_reg[eha_pkg::RNG_W-1:0];
                    out_ratio_next   = ratio_reg;
                    out_level_next   = level_reg;
                    out_changed_next = changed_w;
                    out_inv_next     = !valid_reg;
                    state_next       = eha_pkg::ST_IDLE;
                end
            end
            default: state_next = eha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eha_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg          <= 1'b1;
            round_reg        <= 1'b1;
            hold_samples_reg <= 8'd10;
            low_reg          <= '0;
            high_reg         <= EW'(eha_pkg::ONE_V);
            hold_reg         <= 8'd0;
            shown_low_reg    <= '0;
            shown_high_reg   <= eha_pkg::ONE_V;
            ratio_reg        <= eha_pkg::UNITY_Q16;
            m_valid_reg      <= 1'b0;
        end else begin
            pin_reg          <= pin_next;
            round_reg        <= round_next;
            hold_samples_reg <= hold_samples_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            hold_reg         <= hold_next;
            shown_low_reg    <= shown_low_next;
            shown_high_reg   <= shown_high_next;
            ratio_reg        <= ratio_next;
            m_valid_reg      <= m_valid_next;
        end
        s_reg           <= s_next;
        valid_reg       <= valid_next;
        old_lo_reg      <= old_lo_next;
        old_hi_reg      <= old_hi_next;
        level_reg       <= level_next;
        prod_reg        <= prod_next;
        mn_reg          <= mn_next;
        mx_reg          <= mx_next;
        x_reg           <= x_next;
        k_reg           <= k_next;
        e_reg           <= e_next;
        st_reg          <= st_next;
        q_level_reg     <= q_level_next;
        out_lo_reg      <= out_lo_next;
        out_hi_reg      <= out_hi_next;
        out_ratio_reg   <= out_ratio_next;
        out_level_reg   <= out_level_next;
        out_changed_reg <= out_changed_next;
        out_inv_reg     <= out_inv_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_level_reg, out_ratio_reg, out_hi_reg, out_lo_reg};
    assign m_tuser  = {out_inv_reg, out_changed_reg};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a beat is in flight");

    a_range_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_hi_reg > out_lo_reg))
        else $error("range maximum not above minimum");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_level_reg <= eha_pkg::LVL_W'(eha_pkg::UNITY_Q16)))
        else $error("level above one");

    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == eha_pkg::ST_WAIT_MN ||
                          state_reg == eha_pkg::ST_WAIT_MX ||
                          state_reg == eha_pkg::ST_WAIT_Q))
        else $error("divider finished outside a wait step");

endmodule
